@@ hdl/gspvd_pkg.sv @@
// shared types, widths and constants of the gaussian smoothing peak/valley detector
// also builds the q1.15 gaussian weight table at elaboration
// no dependencies
package gspvd_pkg;

   // build-time configuration
   localparam int GSPVD_EXT   = 31;
   localparam int GSPVD_SIGMA = 8;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 16;
   localparam int VALUE_W  = 22;
   localparam int EXTENT_W = 5;
   localparam int WEIGHT_W = 16;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 22'd4128705;

   // per-request result cap
   localparam int MAX_RESULTS = 32;
   localparam int RC_W        = $clog2(MAX_RESULTS + 1);

   // adder tree: 64 leaves, reduced by 4 per stage
   localparam int LEAVES = 64;
   localparam int GROUP  = 4;
   localparam int N2     = LEAVES / GROUP;
   localparam int N3     = N2 / GROUP;

   // csr map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_EXTENT    = 1'd1;
   localparam logic [EXTENT_W-1:0]  EXTENT_RESET         = 5'd31;

   // weight table constants
   localparam longint unsigned Q30       = 64'd1073741824;
   localparam longint unsigned E1Q30     = 64'd395007542;
   localparam longint unsigned GAUSS_DEN = 64'(2 * GSPVD_SIGMA * GSPVD_SIGMA);

   // bookkeeping that travels with one window evaluation
   typedef struct packed {
      logic             final_put;
      logic             emit;
      logic             keep;
      logic [POS_W-1:0] pos;
   } gspvd_tag_type;

   // one step from the sequencer into the filter
   typedef struct packed {
      logic                push;
      logic                clear;
      logic                send;
      logic [SAMPLE_W-1:0] sample;
      gspvd_tag_type       tag;
   } gspvd_step_type;

   // restoring division, elaboration use only
   function automatic logic [63:0] div_small(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [WEIGHT_W-1:0] gauss_weight(input int unsigned j);
      longint unsigned jj;
      longint unsigned x;
      longint unsigned n;
      longint unsigned f;
      longint unsigned t;
      longint unsigned acc_pos;
      longint unsigned acc_neg;
      longint unsigned e;
      logic [WEIGHT_W-1:0] w;
      jj      = 64'(j);
      x       = ((jj * jj) << 30) / GAUSS_DEN;
      n       = x >> 30;
      f       = x & (Q30 - 64'd1);
      t       = Q30;
      acc_pos = Q30;
      acc_neg = 64'd0;
      w       = '0;
      if (n < 64'd16) begin
         for (int unsigned k = 1; k <= 20; k++) begin
            t = div_small((t * f) >> 30, 64'(k));
            if (k[0]) acc_neg = acc_neg + t;
            else      acc_pos = acc_pos + t;
         end
         e = (acc_pos > acc_neg) ? acc_pos - acc_neg : 64'd0;
         for (int unsigned i = 0; i < 16; i++) begin
            if (64'(i) < n) e = (e * E1Q30 + (Q30 >> 1)) >> 30;
         end
         w = WEIGHT_W'((e * 64'd32768 + (Q30 >> 1)) >> 30);
      end
      return w;
   endfunction

endpackage

@@ hdl/gspvd_ifs.sv @@
// request and response channel interfaces, valid/ready handshake
// depends on gspvd_pkg
interface gspvd_req_if import gspvd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_value;
   logic                last_sample;

   modport source(output valid, sample_value, last_sample, input ready);
   modport sink(input valid, sample_value, last_sample, output ready);
endinterface

interface gspvd_rsp_if import gspvd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   position;
   logic [VALUE_W-1:0] smoothed_value;
   logic               is_summit;
   logic               is_bottom;
   logic               last_result;

   modport source(output valid, position, smoothed_value, is_summit, is_bottom, last_result,
                  input ready);
   modport sink(input valid, position, smoothed_value, is_summit, is_bottom, last_result,
                output ready);
endinterface

@@ hdl/gspvd_fir.sv @@
// sample window and symmetric gaussian fir: product stage and three-stage adder tree
// depends on gspvd_pkg
module gspvd_fir import gspvd_pkg::*; #(
   parameter int EXT = GSPVD_EXT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 smoothing_enable,
   input  logic [EXTENT_W-1:0]  active_extent,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gspvd_step_type       in_step,
   output logic                 out_valid,
   input  logic                 out_ready,
   output gspvd_tag_type        out_tag,
   output logic [VALUE_W-1:0]   out_value
);

   localparam int WIN   = 2 * EXT + 1;
   localparam int TAP_W = 7;
   localparam int P_W   = 2 * SAMPLE_W + 1;
   localparam int S2_W  = P_W + 2;
   localparam int S3_W  = S2_W + 2;
   localparam int S4_W  = S3_W + 2;
   localparam int RND_W = S4_W + 1;

   logic [SAMPLE_W-1:0] win_ff [WIN];
   logic [SAMPLE_W-1:0] win_in [WIN];
   logic [P_W-1:0]      prod_in [LEAVES];

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   gspvd_tag_type       s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;
   logic [SAMPLE_W-1:0] s1_raw_ff, s2_raw_ff, s3_raw_ff;
   logic [P_W-1:0]      s1_prod_ff [LEAVES];
   logic [S2_W-1:0]     s2_sum_ff [N2];
   logic [S2_W-1:0]     s2_sum_in [N2];
   logic [S3_W-1:0]     s3_sum_ff [N3];
   logic [S3_W-1:0]     s3_sum_in [N3];
   logic [S4_W-1:0]     total;
   logic [RND_W-1:0]    rounded;
   logic [RND_W-16:0]   scaled;
   logic [VALUE_W-1:0]  s4_value_ff, s4_value_in;

   logic ld1, ld2, ld3, ld4, in_fire;

   assign ld4      = !s4_valid_ff || out_ready;
   assign ld3      = !s3_valid_ff || ld4;
   assign ld2      = !s2_valid_ff || ld3;
   assign ld1      = !s1_valid_ff || ld2;
   assign in_ready = ld1;
   assign in_fire  = in_valid && ld1;

   // window after this step: newest sample at index 0
   always_comb begin
      for (int i = 0; i < WIN; i++) win_in[i] = win_ff[i];
      if (in_step.clear) begin
         for (int i = 0; i < WIN; i++) win_in[i] = '0;
      end else if (in_step.push) begin
         win_in[0] = in_step.sample;
         for (int i = 1; i < WIN; i++) win_in[i] = win_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN; i++) win_ff[i] <= '0;
      end else if (in_fire) begin
         for (int i = 0; i < WIN; i++) win_ff[i] <= win_in[i];
      end
   end

   // symmetric taps: pre-add the mirrored pair, then one constant multiply
   for (genvar j = 0; j < LEAVES; j++) begin : g_tap
      if (j == 0) begin : g_center
         localparam logic [WEIGHT_W-1:0] WJ = gauss_weight(j);
         assign prod_in[j] = P_W'(win_in[EXT]) * P_W'(WJ);
      end else if (j <= EXT) begin : g_pair
         localparam logic [WEIGHT_W-1:0] WJ = gauss_weight(j);
         logic [SAMPLE_W:0] pair;
         logic              tap_on;
         assign pair       = {1'b0, win_in[EXT-j]} + {1'b0, win_in[EXT+j]};
         assign tap_on     = TAP_W'(j) <= TAP_W'(active_extent);
         assign prod_in[j] = tap_on ? P_W'(pair) * P_W'(WJ) : '0;
      end else begin : g_unused
         assign prod_in[j] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < N2; g++) begin
         s2_sum_in[g] = S2_W'(s1_prod_ff[GROUP*g]) + S2_W'(s1_prod_ff[GROUP*g+1])
                      + S2_W'(s1_prod_ff[GROUP*g+2]) + S2_W'(s1_prod_ff[GROUP*g+3]);
      end
      for (int g = 0; g < N3; g++) begin
         s3_sum_in[g] = S3_W'(s2_sum_ff[GROUP*g]) + S3_W'(s2_sum_ff[GROUP*g+1])
                      + S3_W'(s2_sum_ff[GROUP*g+2]) + S3_W'(s2_sum_ff[GROUP*g+3]);
      end
   end

   // final add, round half up out of q15, clamp; raw center sample when smoothing is off
   always_comb begin
      total   = S4_W'(s3_sum_ff[0]) + S4_W'(s3_sum_ff[1])
              + S4_W'(s3_sum_ff[2]) + S4_W'(s3_sum_ff[3]);
      rounded = RND_W'(total) + RND_W'(16384);
      scaled  = rounded[RND_W-1:15];
      if (!smoothing_enable)                s4_value_in = VALUE_W'(s3_raw_ff);
      else if (scaled > (RND_W-15)'(VALUE_MAX)) s4_value_in = VALUE_MAX;
      else                                  s4_value_in = scaled[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_valid_ff <= in_fire && in_step.send;
         if (ld2) s2_valid_ff <= s1_valid_ff;
         if (ld3) s3_valid_ff <= s2_valid_ff;
         if (ld4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_tag_ff <= in_step.tag;
         s1_raw_ff <= win_in[EXT];
         for (int i = 0; i < LEAVES; i++) s1_prod_ff[i] <= prod_in[i];
      end
      if (ld2) begin
         s2_tag_ff <= s1_tag_ff;
         s2_raw_ff <= s1_raw_ff;
         for (int i = 0; i < N2; i++) s2_sum_ff[i] <= s2_sum_in[i];
      end
      if (ld3) begin
         s3_tag_ff <= s2_tag_ff;
         s3_raw_ff <= s2_raw_ff;
         for (int i = 0; i < N3; i++) s3_sum_ff[i] <= s3_sum_in[i];
      end
      if (ld4) begin
         s4_tag_ff   <= s3_tag_ff;
         s4_value_ff <= s4_value_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_tag   = s4_tag_ff;
   assign out_value = s4_value_ff;

endmodule

@@ hdl/gaussian_smooth_peak_valley_detect.sv @@
// top level: csr registers, profile sequencer with end-of-profile flush,
// summit/bottom detection and response register; depends on gspvd_pkg, gspvd_ifs, gspvd_fir
//
// throughput: one request per cycle while a profile streams and responses are not held off;
//   a last request starts a request-free flush that emits the remaining responses
// the response for position p is formed from request p+EXT+1, which passes the remaining
//   fir stages and the response register before the response is offered
// reset (synchronous, active high) clears the window, counters and valid flags, sets the
//   direction to rising; smoothing starts off and the active extent at 31
module gaussian_smooth_peak_valley_detect import gspvd_pkg::*; #(
   parameter int EXT = GSPVD_EXT
) (
   input  logic                  clock,
   input  logic                  reset,
   gspvd_req_if.sink             req_chan,
   gspvd_rsp_if.source           rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int ZL_W = $clog2(EXT + 1);

   // csr state
   logic                smooth_en_ff;
   logic [EXTENT_W-1:0] extent_ff;

   // sequencer state
   logic [POS_W-1:0] count_ff;
   logic             hprev_ff;
   logic             flush_ff;
   logic [ZL_W-1:0]  zleft_ff;
   logic [RC_W-1:0]  rcount_ff;

   // detection state
   logic               dir_ff;
   logic [VALUE_W-1:0] prev_val_ff;
   logic [POS_W-1:0]   prev_pos_ff;

   // response register
   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [VALUE_W-1:0] rsp_val_ff;
   logic               rsp_summit_ff;
   logic               rsp_bottom_ff;
   logic               rsp_last_ff;

   // sequencer signals
   logic            final_step;
   logic            compute;
   logic            step_valid;
   logic            step_fire;
   logic            req_fire;
   logic [RC_W-1:0] rc_base;
   logic            keep;
   gspvd_step_type  step;
   logic            fir_ready;

   // fir output and detection signals
   logic               fir_valid;
   gspvd_tag_type      fir_tag;
   logic [VALUE_W-1:0] fir_value;
   logic               det_ready;
   logic               consume;
   logic               dir_new;
   logic               out_fire;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_en_ff <= 1'b0;
         extent_ff    <= EXTENT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SMOOTHING_ENABLE) smooth_en_ff <= csr_write_data[0];
         else if (csr_index == CSR_ACTIVE_EXTENT) extent_ff <= csr_write_data[EXTENT_W-1:0];
      end
   end

   // sequencer: a request is one window push; during flush the sequencer pushes
   // EXT zero samples itself and then a final put that reports the last position
   assign final_step     = flush_ff && (zleft_ff == '0);
   assign step_valid     = flush_ff || req_chan.valid;
   assign req_chan.ready = !flush_ff && fir_ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign step_fire      = step_valid && fir_ready;

   // a window is evaluated once the center position exists
   assign compute = hprev_ff || (count_ff >= POS_W'(EXT));

   // results per request are capped; the count restarts with each request
   assign rc_base = flush_ff ? rcount_ff : '0;
   assign keep    = rc_base < RC_W'(MAX_RESULTS);

   always_comb begin
      step.push          = !final_step;
      step.clear         = final_step;
      step.send          = final_step || compute;
      step.sample        = flush_ff ? '0 : req_chan.sample_value;
      step.tag.final_put = final_step;
      step.tag.emit      = hprev_ff;
      step.tag.keep      = keep;
      step.tag.pos       = count_ff - POS_W'(EXT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         hprev_ff  <= 1'b0;
         flush_ff  <= 1'b0;
         zleft_ff  <= '0;
         rcount_ff <= '0;
      end else if (step_fire) begin
         if (final_step) begin
            // profile done, next request starts at position 0
            count_ff <= '0;
            hprev_ff <= 1'b0;
            flush_ff <= 1'b0;
         end else begin
            count_ff  <= count_ff + 1'b1;
            hprev_ff  <= hprev_ff || compute;
            rcount_ff <= (hprev_ff && keep) ? rc_base + 1'b1 : rc_base;
            if (flush_ff) begin
               zleft_ff <= zleft_ff - 1'b1;
            end else if (req_chan.last_sample) begin
               flush_ff <= 1'b1;
               zleft_ff <= ZL_W'(EXT);
            end
         end
      end
   end

   gspvd_fir #(
      .EXT(EXT)
   ) u_fir (
      .clock            (clock),
      .reset            (reset),
      .smoothing_enable (smooth_en_ff),
      .active_extent    (extent_ff),
      .in_valid         (step_valid),
      .in_ready         (fir_ready),
      .in_step          (step),
      .out_valid        (fir_valid),
      .out_ready        (det_ready),
      .out_tag          (fir_tag),
      .out_value        (fir_value)
   );

   // detection: compare each new value with the one held back, report the held one
   assign det_ready = !rsp_valid_ff || rsp_chan.ready;
   assign consume   = fir_valid && det_ready;
   assign out_fire  = consume && fir_tag.emit && fir_tag.keep;

   always_comb begin
      dir_new = dir_ff;
      if (fir_value > prev_val_ff)      dir_new = 1'b1;
      else if (fir_value < prev_val_ff) dir_new = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff      <= 1'b1;
         prev_val_ff <= '0;
         prev_pos_ff <= '0;
      end else if (consume) begin
         if (fir_tag.final_put) begin
            dir_ff      <= 1'b1;
            prev_val_ff <= '0;
            prev_pos_ff <= '0;
         end else begin
            // dropped results still move the direction
            if (fir_tag.emit) dir_ff <= dir_new;
            prev_val_ff <= fir_value;
            prev_pos_ff <= fir_tag.pos;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         rsp_pos_ff    <= prev_pos_ff;
         rsp_val_ff    <= prev_val_ff;
         rsp_summit_ff <= !fir_tag.final_put && !dir_new && dir_ff;
         rsp_bottom_ff <= !fir_tag.final_put && dir_new && !dir_ff;
         rsp_last_ff   <= fir_tag.final_put;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.position       = rsp_pos_ff;
   assign rsp_chan.smoothed_value = rsp_val_ff;
   assign rsp_chan.is_summit      = rsp_summit_ff;
   assign rsp_chan.is_bottom      = rsp_bottom_ff;
   assign rsp_chan.last_result    = rsp_last_ff;

   // no request is taken while the flush runs
   a_no_req_in_flush: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !req_chan.ready)
      else $error("request accepted during flush");

   // a last request starts the flush
   a_last_starts_flush: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.last_sample |=> flush_ff)
      else $error("last request did not start flush");

   // the final put restarts the profile
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      step_fire && final_step |=> (count_ff == '0) && !hprev_ff && !flush_ff)
      else $error("profile state not cleared after final put");

   // a position is never both summit and bottom
   a_marks_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_summit_ff && rsp_bottom_ff))
      else $error("summit and bottom on one position");

   // the final position is never marked
   a_last_unmarked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> !rsp_summit_ff && !rsp_bottom_ff)
      else $error("final position marked");

endmodule

@@ tb/gspvd_profile_checker.sv @@
// checker for the gaussian smoothing summit/bottom detector: watches both channels and the
// csr port, predicts every response and compares it field by field
// depends on gspvd_pkg and gspvd_ifs
`timescale 1ns / 1ps

module gspvd_profile_checker import gspvd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   gspvd_req_if                  req_mon,
   gspvd_rsp_if                  rsp_mon,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    points_outstanding
);

   localparam int EXT = GSPVD_EXT;
   localparam int WIN = 2 * EXT + 1;
   localparam longint unsigned ONE_Q30  = 64'd1 << 30;
   localparam longint unsigned HALF_Q30 = 64'd1 << 29;
   localparam longint unsigned INV_E    = 64'd395007542;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] smoothed_value;
      logic               is_summit;
      logic               is_bottom;
      logic               last_result;
   } profile_point_type;

   longint unsigned     gauss_tap [0:EXT];
   logic [SAMPLE_W-1:0] sample_window [0:WIN-1];
   logic [POS_W-1:0]    sample_count;
   logic [VALUE_W-1:0]  held_value;
   logic [POS_W-1:0]    held_position;
   logic                rising;
   logic                have_held;
   logic                smoothing_on;
   logic [EXTENT_W-1:0] extent;
   int                  step_emitted;
   profile_point_type   expected_points [$];

   // q1.15 gaussian tap from a truncated taylor series of exp in q30
   function automatic longint unsigned tap_weight(input int j);
      longint unsigned jj;
      longint unsigned x;
      longint unsigned n;
      longint unsigned f;
      longint unsigned t;
      longint unsigned plus;
      longint unsigned minus;
      longint unsigned e;
      jj = longint'(j);
      x  = ((jj * jj) << 30) / longint'(2 * GSPVD_SIGMA * GSPVD_SIGMA);
      n  = x >> 30;
      f  = x & (ONE_Q30 - 1);
      if (n >= 16) return 0;
      t     = ONE_Q30;
      plus  = ONE_Q30;
      minus = 0;
      for (int k = 1; k <= 20; k++) begin
         t = ((t * f) >> 30) / longint'(k);
         if (k % 2 == 1) minus += t;
         else plus += t;
      end
      e = (plus > minus) ? plus - minus : 0;
      for (longint unsigned i = 0; i < n; i++) e = (e * INV_E + HALF_Q30) >> 30;
      return (e * 32768 + HALF_Q30) >> 30;
   endfunction

   initial begin
      for (int j = 0; j <= EXT; j++) gauss_tap[j] = tap_weight(j);
   end

   function automatic logic [VALUE_W-1:0] window_center();
      longint unsigned acc;
      int              span;
      if (!smoothing_on) return VALUE_W'(sample_window[EXT]);
      span = (int'(extent) > EXT) ? EXT : int'(extent);
      acc  = longint'(sample_window[EXT]) * gauss_tap[0];
      for (int j = 1; j <= span; j++) begin
         acc += longint'(sample_window[EXT - j]) * gauss_tap[j];
         acc += longint'(sample_window[EXT + j]) * gauss_tap[j];
      end
      acc = (acc + 16384) >> 15;
      if (acc > longint'(VALUE_MAX)) return VALUE_MAX;
      return acc[VALUE_W-1:0];
   endfunction

   task automatic clear_profile();
      foreach (sample_window[i]) sample_window[i] = '0;
      sample_count  = '0;
      held_value    = '0;
      held_position = '0;
      rising        = 1'b1;
      have_held     = 1'b0;
   endtask

   // one request yields at most MAX_RESULTS responses, the rest are lost
   task automatic record_point(input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] value,
                               input logic summit, input logic bottom, input logic last);
      profile_point_type point;
      if (step_emitted < MAX_RESULTS) begin
         point           = '{pos, value, summit, bottom, last};
         expected_points = {expected_points, point};
         step_emitted++;
      end
   endtask

   task automatic shift_in(input logic [SAMPLE_W-1:0] sample);
      logic [VALUE_W-1:0] center;
      logic               next_rising;
      for (int i = WIN - 1; i > 0; i--) sample_window[i] = sample_window[i-1];
      sample_window[0] = sample;
      if (have_held || sample_count >= EXT) begin
         center = window_center();
         if (have_held) begin
            next_rising = rising;
            if (center > held_value) next_rising = 1'b1;
            else if (center < held_value) next_rising = 1'b0;
            record_point(held_position, held_value, !next_rising && rising,
                         next_rising && !rising, 1'b0);
            rising = next_rising;
         end
         held_value    = center;
         held_position = POS_W'(sample_count - EXT);
         have_held     = 1'b1;
      end
      sample_count = sample_count + 1'b1;
   endtask

   task automatic take_request(input logic [SAMPLE_W-1:0] sample, input logic last);
      step_emitted = 0;
      shift_in(sample);
      if (last) begin
         repeat (EXT) shift_in('0);
         if (have_held) record_point(held_position, held_value, 1'b0, 1'b0, 1'b1);
         clear_profile();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_point();
      profile_point_type want;
      if (expected_points.size() == 0) begin
         $error("response with nothing expected at position %0d", rsp_mon.position);
         mismatch_count++;
      end else begin
         want = expected_points.pop_front();
         check_field("position", 32'(want.position), 32'(rsp_mon.position));
         check_field("smoothed_value", 32'(want.smoothed_value), 32'(rsp_mon.smoothed_value));
         check_field("is_summit", 32'(want.is_summit), 32'(rsp_mon.is_summit));
         check_field("is_bottom", 32'(want.is_bottom), 32'(rsp_mon.is_bottom));
         check_field("last_result", 32'(want.last_result), 32'(rsp_mon.last_result));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_profile();
         smoothing_on = 1'b0;
         extent       = EXTENT_RESET;
         step_emitted = 0;
         expected_points.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) compare_point();
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SMOOTHING_ENABLE: smoothing_on = csr_write_data[0];
               CSR_ACTIVE_EXTENT:    extent = csr_write_data[EXTENT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            take_request(req_mon.sample_value, req_mon.last_sample);
      end
      points_outstanding = expected_points.size();
   end

endmodule

@@ tb/tb_gaussian_smooth_peak_valley_detect.sv @@
// top of the gaussian smoothing summit/bottom detector testbench: clock, reset, csr writes,
// request stimulus, response back-pressure and the verdict
// depends on gspvd_pkg, gspvd_ifs, the block and gspvd_profile_checker
`timescale 1ns / 1ps

module tb_gaussian_smooth_peak_valley_detect;
   import gspvd_pkg::*;

   localparam int EXT          = GSPVD_EXT;
   // flush plus the pipeline, with margin
   localparam int DRAIN_CYCLES = 2 * (EXT + 1) + 16;
   // long hold-off of the response side, well past the block's buffering
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 50_000;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef enum int {SHAPE_WALK, SHAPE_NOISE, SHAPE_LOW, SHAPE_HIGH} shape_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    mismatch_count;
   int                    points_outstanding;

   // stimulus knobs, each written by one process only
   bit         gapless;
   bit         fast_drain;
   bit         pressure_on;
   bit         stall_done;
   int         random_sent;
   sample_type fixed_profile [$];

   gspvd_req_if req_chan ();
   gspvd_rsp_if rsp_chan ();

   gaussian_smooth_peak_valley_detect u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   gspvd_profile_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_chan),
      .rsp_mon            (rsp_chan),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .points_outstanding (points_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // response side: random ready with mostly short holds, a few long ones, and one
   // very long hold-off while the pressure phase streams requests
   // ---------------------------------------------------------------------------------
   function automatic int pick_hold();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      rsp_chan.ready = 1'b1;
      forever begin
         rsp_chan.ready = 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
         if (pressure_on && !stall_done) begin
            // block fills up and must stall its request side
            stall_done     = 1'b1;
            rsp_chan.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!fast_drain) begin
            rsp_chan.ready = 1'b0;
            repeat (pick_hold()) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // request side helpers
   // ---------------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (gapless) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // one request; entered and left at a falling edge
   task automatic send_sample(input sample_type value, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.sample_value = value;
      req_chan.last_sample  = last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_fixed_profile();
      foreach (fixed_profile[i]) send_sample(fixed_profile[i], i == fixed_profile.size() - 1);
   endtask

   function automatic sample_type draw_sample(input sample_type prior, input shape_type shape);
      int level;
      case (shape)
         SHAPE_WALK: begin
            // plateaus are frequent so that flat summits and bottoms show up
            if ($urandom_range(0, 99) < 25) return prior;
            level = int'(prior) + int'($urandom_range(0, 4000)) - 2000;
            if (level < 0) level = 0;
            if (level > 65535) level = 65535;
            return sample_type'(level);
         end
         SHAPE_LOW:  return sample_type'($urandom_range(0, 3));
         SHAPE_HIGH: return sample_type'($urandom_range(65532, 65535));
         default:    return sample_type'($urandom);
      endcase
   endfunction

   function automatic shape_type pick_shape();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return SHAPE_WALK;
      if (r < 75) return SHAPE_NOISE;
      if (r < 90) return SHAPE_LOW;
      return SHAPE_HIGH;
   endfunction

   // most profiles fit one flush (last result seen), some overflow it,
   // and a few sit right on the edge of the per-request result cap
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return $urandom_range(32, 33);
      if (r < 70) return $urandom_range(1, 40);
      return $urandom_range(41, 90);
   endfunction

   task automatic send_profile(input int len, input shape_type shape);
      sample_type level;
      level = sample_type'($urandom);
      for (int i = 0; i < len; i++) begin
         level = draw_sample(level, shape);
         send_sample(level, i == len - 1);
      end
      random_sent += len;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // wait for the block to drain before touching the registers
   task automatic settle();
      req_chan.valid = 1'b0;
      wait (points_outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // stimulus and verdict
   // ---------------------------------------------------------------------------------
   initial begin
      int phase_target;
      req_chan.valid        = 1'b0;
      req_chan.sample_value = '0;
      req_chan.last_sample  = 1'b0;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_SMOOTHING_ENABLE;
      csr_write_data        = '0;
      gapless               = 1'b0;
      fast_drain            = 1'b0;
      pressure_on           = 1'b0;
      random_sent           = 0;
      reset                 = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: raw detection first
      write_reg(CSR_SMOOTHING_ENABLE, 5'd0);
      write_reg(CSR_ACTIVE_EXTENT, 5'd31);
      // single-sample profile at full scale, flushed alone
      fixed_profile = '{16'hFFFF};
      send_fixed_profile();
      // plateau on the rise, summit, flat bottom, second summit, fall into the last position
      fixed_profile = '{16'd0, 16'd200, 16'd200, 16'd700, 16'd50, 16'd50, 16'd300, 16'd0};
      send_fixed_profile();
      settle();

      // smoothing with a zero-width window: only the center tap
      write_reg(CSR_SMOOTHING_ENABLE, 5'd1);
      write_reg(CSR_ACTIVE_EXTENT, 5'd0);
      fixed_profile = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
      send_fixed_profile();
      settle();

      // full window on an impulse, zeros read past both ends
      write_reg(CSR_ACTIVE_EXTENT, 5'd31);
      fixed_profile = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0};
      send_fixed_profile();

      // random phases, each under its own register setting
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         case (phase)
            0: begin
               write_reg(CSR_SMOOTHING_ENABLE, 5'd0);
               write_reg(CSR_ACTIVE_EXTENT, 5'd31);
            end
            1: write_reg(CSR_SMOOTHING_ENABLE, 5'd1);
            2: write_reg(CSR_ACTIVE_EXTENT, 5'd0);
            3: write_reg(CSR_ACTIVE_EXTENT, 5'd1);
            4: write_reg(CSR_ACTIVE_EXTENT, CSR_DATA_W'($urandom_range(2, 30)));
            5: begin
               write_reg(CSR_SMOOTHING_ENABLE, 5'd0);
               write_reg(CSR_ACTIVE_EXTENT, 5'd0);
            end
            6: begin
               write_reg(CSR_SMOOTHING_ENABLE, 5'd1);
               write_reg(CSR_ACTIVE_EXTENT, 5'd31);
            end
            default: begin
               write_reg(CSR_ACTIVE_EXTENT, CSR_DATA_W'($urandom_range(0, 31)));
               // a stretch with no idling on either side
               gapless    = 1'b1;
               fast_drain = 1'b1;
            end
         endcase
         if (phase == 6) begin
            // back-to-back requests while the response side holds off
            gapless     = 1'b1;
            pressure_on = 1'b1;
            send_profile(60, SHAPE_WALK);
            pressure_on = 1'b0;
            gapless     = 1'b0;
         end
         phase_target = random_sent + 5;
         while (random_sent < phase_target) send_profile(pick_length(), pick_shape());
      end

      settle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
